FILE: hw/rtl/nstp_pkg.sv
// Shared constants and types of the nested section time profiler.
// Field widths, saturation limits, event codes and the shared adder opcodes.
// No dependencies; compile first.
package nstp_pkg;

  localparam int TID_W         = 4;
  localparam int TS_W          = 48;
  localparam int CNT_W         = 32;
  localparam int COST_W        = 48;
  localparam int NEST_W        = 16;
  localparam int OUT_W         = 24;

  localparam int THREADS_DEF   = 16;
  localparam int TIME_BITS_DEF = 48;

  localparam logic signed [NEST_W-1:0] NEST_MAX = 16'sh7FFF;
  localparam logic signed [NEST_W-1:0] NEST_MIN = 16'sh8000;
  localparam logic signed [OUT_W-1:0]  OUT_MAX  = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0]  OUT_MIN  = 24'sh800000;

  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

FILE: hw/rtl/nstp_if.sv
// Valid/ready channel interfaces of the nested section time profiler.
// Depends on nstp_pkg for the field widths.
interface nstp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [nstp_pkg::TID_W-1:0]  thread_id;
  logic [nstp_pkg::TS_W-1:0]   timestamp;

  modport source (output valid, kind, thread_id, timestamp, input ready);
  modport sink   (input valid, kind, thread_id, timestamp, output ready);
endinterface

interface nstp_out_if;
  logic                               valid;
  logic                               ready;
  logic [nstp_pkg::CNT_W-1:0]         thread_calls;
  logic [nstp_pkg::COST_W-1:0]        thread_cost;
  logic signed [nstp_pkg::NEST_W-1:0] thread_nesting;
  logic [nstp_pkg::CNT_W-1:0]         total_calls;
  logic [nstp_pkg::COST_W-1:0]        total_cost;
  logic                               mismatch;

  modport source (output valid, thread_calls, thread_cost, thread_nesting,
                  total_calls, total_cost, mismatch, input ready);
  modport sink   (input valid, thread_calls, thread_cost, thread_nesting,
                  total_calls, total_cost, mismatch, output ready);
endinterface

FILE: hw/rtl/nested_section_time_profiler.sv
// Nested section time profiler, top level: sequencer, per-thread RAM, totals.
// Depends on nstp_pkg, nstp_if, nstp_ram and nstp_alu.
//
//   channel  | dir | word                                              | handshake
//   ---------+-----+---------------------------------------------------+-------------
//   in_ch    | in  | kind, thread_id, timestamp                        | valid/ready
//   out_ch   | out | thread_calls, thread_cost, thread_nesting,        | valid/ready
//            |     | total_calls, total_cost, mismatch                 |
//
// Steps: a begin word, an end word that adds no time, or a word for a thread
//   out of range passes through the read, load and write-back steps; an end
//   word that adds elapsed time also passes through the subtract, thread-add,
//   cost-add and total steps, as the shared adder runs the elapsed difference,
//   the thread cost and the total cost one by one.
// Reset: synchronous, active low. After reset a clearing pass writes every
//   per-thread RAM entry to zero, one per cycle; in_ch
//   is not ready until it ends.
// Stalls: one word is in work at a time. The result register holds until
//   taken; a new word may be accepted while it waits, and that word's result
//   holds in the write-back step until the register is free.
module nested_section_time_profiler #(
  parameter int THREADS   = nstp_pkg::THREADS_DEF,
  parameter int TIME_BITS = nstp_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nstp_in_if.sink    in_ch,
  nstp_out_if.source out_ch
);
  import nstp_pkg::*;

  localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int AW = (TIME_BITS > COST_W) ? TIME_BITS : COST_W;

  // one RAM word per thread
  typedef struct packed {
    logic [CNT_W-1:0]         calls;
    logic signed [NEST_W-1:0] nest;
    logic [TIME_BITS-1:0]     bt;
    logic                     bv;
    logic [COST_W-1:0]        cost;
  } rec_t;

  localparam int RW = $bits(rec_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_SUB,
    S_ADDT,
    S_ADDC,
    S_TOT,
    S_WB
  } state_t;

  state_t                   state_r;
  logic [IW-1:0]            clr_r;
  logic                     kind_r;
  logic [IW-1:0]            idx_r;
  logic [TS_W-1:0]          ts_r;
  logic                     hit_r;
  rec_t                     rec_r;
  logic [COST_W-1:0]        el_r;
  logic signed [OUT_W-1:0]  nest_tot_r;
  logic [CNT_W-1:0]         calls_tot_r;
  logic [COST_W-1:0]        cost_tot_r;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [CNT_W-1:0]         o_calls_r;
  logic [COST_W-1:0]        o_cost_r;
  logic signed [NEST_W-1:0] o_nest_r;
  logic [CNT_W-1:0]         o_tcalls_r;
  logic [COST_W-1:0]        o_tcost_r;
  logic                     o_mis_r;

  logic                     accept;
  logic                     out_stall;
  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic [RW-1:0]            ram_wdata;
  logic [RW-1:0]            ram_rdata;
  rec_t                     rd;
  rec_t                     upd;
  logic signed [OUT_W-1:0]  nest_tot_nxt;
  logic [CNT_W-1:0]         calls_tot_nxt;
  logic                     cost_need;
  alu_op_t                  alu_op;
  logic [AW-1:0]            alu_a;
  logic [AW-1:0]            alu_b;
  logic [COST_W-1:0]        alu_q;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_stall   = out_valid_r && !out_ch.ready;

  // load the result register from write-back, else drop it once taken
  assign out_valid_nxt = ((state_r == S_WB) && !out_stall) ? 1'b1
                                                            : (out_valid_r && !out_ch.ready);

  // Per-thread store: cleared by the sweep, written back once per in-range word.
  assign ram_we    = (state_r == S_CLEAR) || ((state_r == S_WB) && !out_stall && hit_r);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : idx_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : RW'(rec_r);

  nstp_ram #(
    .W (RW),
    .D (THREADS),
    .AW(IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  assign rd = rec_t'(ram_rdata);

  // Counter updates of the fetched record; the wide time sums go to the adder.
  always_comb begin
    upd           = rd;
    nest_tot_nxt  = nest_tot_r;
    calls_tot_nxt = calls_tot_r;
    cost_need     = 1'b0;
    if (kind_r == KIND_BEGIN) begin
      if (rd.calls != {CNT_W{1'b1}}) begin
        upd.calls = rd.calls + CNT_W'(1);
      end
      // latch the start only on the outermost begin
      if (rd.nest == '0) begin
        upd.bt = TIME_BITS'(ts_r);
        upd.bv = 1'b1;
      end
      if (rd.nest != NEST_MAX) begin
        upd.nest = rd.nest + NEST_W'(1);
      end
      if (nest_tot_r != OUT_MAX) begin
        nest_tot_nxt = nest_tot_r + OUT_W'(1);
      end
      if (calls_tot_r != {CNT_W{1'b1}}) begin
        calls_tot_nxt = calls_tot_r + CNT_W'(1);
      end
    end else begin
      if (rd.nest != NEST_MIN) begin
        upd.nest = rd.nest - NEST_W'(1);
      end
      if (nest_tot_r != OUT_MIN) begin
        nest_tot_nxt = nest_tot_r - OUT_W'(1);
      end
      // closing the outermost section (or unbalanced): charge elapsed time
      cost_need = (upd.nest[NEST_W-1] || (upd.nest == '0)) && rd.bv;
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    case (state_r)
      S_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(ts_r);
        alu_b  = AW'(rec_r.bt);
      end
      S_ADDT: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(rec_r.cost);
        alu_b  = AW'(alu_q);
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(cost_tot_r);
        alu_b  = AW'(el_r);
      end
    endcase
  end

  nstp_alu #(
    .TIME_BITS(TIME_BITS),
    .OPW      (AW)
  ) u_alu (
    .clk(clk),
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .q  (alu_q)
  );

  // Sequencer, totals and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nest_tot_r  <= '0;
      calls_tot_r <= '0;
      cost_tot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(THREADS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_r  <= in_ch.kind;
            idx_r   <= IW'(in_ch.thread_id);
            ts_r    <= in_ch.timestamp;
            hit_r   <= (int'(in_ch.thread_id) < THREADS);
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (hit_r) begin
            rec_r       <= upd;
            nest_tot_r  <= nest_tot_nxt;
            calls_tot_r <= calls_tot_nxt;
            state_r     <= cost_need ? S_SUB : S_WB;
          end else begin
            // out of range: report zeros for the thread and leave state alone
            rec_r   <= '0;
            state_r <= S_WB;
          end
        end
        S_SUB: begin
          state_r <= S_ADDT;
        end
        S_ADDT: begin
          el_r    <= alu_q;
          state_r <= S_ADDC;
        end
        S_ADDC: begin
          // negative nesting replaces the cost instead of adding to it
          rec_r.cost <= (rec_r.nest == '0) ? alu_q : el_r;
          state_r    <= S_TOT;
        end
        S_TOT: begin
          cost_tot_r <= alu_q;
          state_r    <= S_WB;
        end
        S_WB: begin
          if (!out_stall) begin
            o_calls_r   <= rec_r.calls;
            o_cost_r    <= rec_r.cost;
            o_nest_r    <= rec_r.nest;
            o_tcalls_r  <= calls_tot_r;
            o_tcost_r   <= cost_tot_r;
            o_mis_r     <= (nest_tot_r != '0);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.thread_calls   = o_calls_r;
  assign out_ch.thread_cost    = o_cost_r;
  assign out_ch.thread_nesting = o_nest_r;
  assign out_ch.total_calls    = o_tcalls_r;
  assign out_ch.total_cost     = o_tcost_r;
  assign out_ch.mismatch       = o_mis_r;

`ifndef NO_ASSERTIONS
  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("result word raised outside write-back");

  a_ram_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_WB))
    else $error("per-thread store written outside sweep or write-back");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_READ))
    else $error("accepted word did not start a store read");

  a_calls_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (calls_tot_r >= $past(calls_tot_r)))
    else $error("total call count went down");

  a_cost_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cost_tot_r >= $past(cost_tot_r)))
    else $error("total cost went down");
`endif

endmodule

FILE: hw/rtl/nstp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nstp_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/nstp_alu.sv
// Shared adder/subtractor of the profiler, with time wrap and cost saturation.
// Depends on nstp_pkg; result registered in the cycle after the operands.
module nstp_alu #(
  parameter int TIME_BITS = nstp_pkg::TIME_BITS_DEF,
  parameter int OPW       = nstp_pkg::COST_W
) (
  input  logic                        clk,
  input  nstp_pkg::alu_op_t           op,
  input  logic [OPW-1:0]              a,
  input  logic [OPW-1:0]              b,
  output logic [nstp_pkg::COST_W-1:0] q
);
  import nstp_pkg::*;

  logic              sub;
  logic [OPW:0]      bop;
  logic [OPW:0]      sum;
  logic [OPW:0]      val;
  logic [OPW:0]      tmask;
  logic [COST_W-1:0] q_nxt;
  logic [COST_W-1:0] q_r;

  assign sub   = (op == ALU_SUB);
  assign tmask = {{(OPW + 1 - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  assign bop   = sub ? ~{1'b0, b} : {1'b0, b};
  assign sum   = {1'b0, a} + bop + (OPW + 1)'(sub);
  // wrap differences to the time width, then clamp anything past the cost range
  assign val   = sub ? (sum & tmask) : sum;
  assign q_nxt = (|val[OPW:COST_W]) ? {COST_W{1'b1}} : val[COST_W-1:0];

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: tb/sv/tb_nested_section_time_profiler.sv
// Self-checking testbench of the nested section time profiler.
// Needs nstp_pkg, nstp_if and the profiler RTL; stands alone otherwise.
module tb_nested_section_time_profiler;
  timeunit 1ns;
  timeprecision 1ps;

  import nstp_pkg::*;

  localparam int THREADS      = THREADS_DEF;
  localparam int QUIET_LIMIT  = 2000;   // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 16;     // settle time once every result is in
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int PRINT_CAP    = 50;

  typedef struct packed {
    logic [CNT_W-1:0]         thread_calls;
    logic [COST_W-1:0]        thread_cost;
    logic signed [NEST_W-1:0] thread_nesting;
    logic [CNT_W-1:0]         total_calls;
    logic [COST_W-1:0]        total_cost;
    logic                     mismatch;
  } profile_result_t;

  typedef struct packed {
    logic                  kind;
    logic [TID_W-1:0]      tid;
    logic [TS_W-1:0]       ts;
    logic                  typed;
    profile_result_t       res;
  } directed_row_t;

  localparam profile_result_t NO_RESULT = '0;
  localparam logic [TS_W-1:0] TS_TOP    = {TS_W{1'b1}};

  // Directed script: hand-typed results only where they are plain to see.
  localparam int SCRIPT_LEN = 19;
  localparam directed_row_t SCRIPT [SCRIPT_LEN] = '{
    // first begin after reset on thread 0, then its matching end
    '{KIND_BEGIN, 4'd0,  48'd0,   1'b1, '{32'd1, 48'd0,   16'sd1, 32'd1, 48'd0,   1'b1}},
    '{KIND_END,   4'd0,  48'd100, 1'b1, '{32'd1, 48'd100, 16'sd0, 32'd1, 48'd100, 1'b0}},
    // end with no begin time ever latched, then a begin at negative nesting
    '{KIND_END,   4'd1,  48'd5,   1'b1, '{32'd0, 48'd0,   -16'sd1, 32'd1, 48'd100, 1'b1}},
    '{KIND_BEGIN, 4'd1,  48'd7,   1'b1, '{32'd1, 48'd0,   16'sd0, 32'd2, 48'd100, 1'b0}},
    // elapsed time across the timestamp wrap
    '{KIND_BEGIN, 4'd2,  48'hFFFF_FFFF_FFF0, 1'b0, NO_RESULT},
    '{KIND_END,   4'd2,  48'h0000_0000_000A, 1'b0, NO_RESULT},
    // nested begin keeps the outer time; largest span; cost saturation
    '{KIND_BEGIN, 4'd15, 48'd0,   1'b0, NO_RESULT},
    '{KIND_BEGIN, 4'd15, 48'd5,   1'b0, NO_RESULT},
    '{KIND_END,   4'd15, 48'd9,   1'b0, NO_RESULT},
    '{KIND_END,   4'd15, TS_TOP,  1'b0, NO_RESULT},
    '{KIND_BEGIN, 4'd15, 48'd0,   1'b0, NO_RESULT},
    '{KIND_END,   4'd15, TS_TOP,  1'b0, NO_RESULT},
    // negative nesting replaces the thread cost; begin there latches nothing
    '{KIND_BEGIN, 4'd4,  48'd10,  1'b0, NO_RESULT},
    '{KIND_END,   4'd4,  48'd20,  1'b0, NO_RESULT},
    '{KIND_END,   4'd4,  48'd50,  1'b0, NO_RESULT},
    '{KIND_BEGIN, 4'd4,  48'd60,  1'b0, NO_RESULT},
    '{KIND_END,   4'd4,  48'd70,  1'b0, NO_RESULT},
    // alternating timestamp bit patterns
    '{KIND_BEGIN, 4'd9,  48'hAAAA_AAAA_AAAA, 1'b0, NO_RESULT},
    '{KIND_END,   4'd9,  48'h5555_5555_5555, 1'b0, NO_RESULT}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5ns clk = ~clk;

  nstp_in_if  in_ch ();
  nstp_out_if out_ch ();

  nested_section_time_profiler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Own copy of the profiler state, advanced on every accepted word.
  logic [CNT_W-1:0]         calls_by_thread [THREADS];
  logic signed [NEST_W-1:0] nest_by_thread  [THREADS];
  logic [TS_W-1:0]          start_time      [THREADS];
  logic                     start_seen      [THREADS];
  logic [COST_W-1:0]        cost_by_thread  [THREADS];
  logic signed [OUT_W-1:0]  open_total;
  logic [CNT_W-1:0]         calls_sum;
  logic [COST_W-1:0]        cost_sum;

  profile_result_t pending_results [$];

  // Sideband travelling with the word on offer: a typed-in result, if any.
  logic            word_typed;
  profile_result_t word_typed_res;

  int   error_count = 0;
  int   quiet_cycles = 0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   hold_token = 0;
  int   depth_plan [THREADS];   // driver's own view of each thread's nesting
  logic [TS_W-1:0] clock_now;

  function automatic logic [COST_W-1:0] cost_sat_add(logic [COST_W-1:0] a,
                                                     logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

  // Apply one event to the state copy and return the result it must produce.
  function automatic profile_result_t profile_event(logic kind, logic [TID_W-1:0] tid,
                                                    logic [TS_W-1:0] ts);
    profile_result_t r;
    logic [TS_W-1:0] span;
    int i;
    r = '0;
    i = int'(tid);
    if (i < THREADS) begin
      if (kind == KIND_BEGIN) begin
        if (calls_by_thread[i] != {CNT_W{1'b1}}) calls_by_thread[i] += 1'b1;
        // latch only when entering from level zero
        if (nest_by_thread[i] == 0) begin
          start_time[i] = ts;
          start_seen[i] = 1'b1;
        end
        if (nest_by_thread[i] != NEST_MAX) nest_by_thread[i] += NEST_W'(1);
        if (open_total != OUT_MAX) open_total += OUT_W'(1);
        if (calls_sum != {CNT_W{1'b1}}) calls_sum += 1'b1;
      end else begin
        if (nest_by_thread[i] != NEST_MIN) nest_by_thread[i] -= NEST_W'(1);
        if (open_total != OUT_MIN) open_total -= OUT_W'(1);
        if (nest_by_thread[i] <= 0 && start_seen[i]) begin
          span = ts - start_time[i];   // wraps modulo 2^48
          // level zero accumulates, below zero the span replaces the cost
          if (nest_by_thread[i] == 0)
            cost_by_thread[i] = cost_sat_add(cost_by_thread[i], span);
          else
            cost_by_thread[i] = span;
          cost_sum = cost_sat_add(cost_sum, span);
        end
      end
      r.thread_calls   = calls_by_thread[i];
      r.thread_cost    = cost_by_thread[i];
      r.thread_nesting = nest_by_thread[i];
    end
    r.total_calls = calls_sum;
    r.total_cost  = cost_sum;
    r.mismatch    = (open_total != 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Monitor: predict on input acceptance, check on result acceptance, and
  // keep the watchdog. One process, so order within the edge is fixed.
  always @(posedge clk) begin
    profile_result_t want;
    logic in_take;
    logic out_take;
    in_take  = rst_n && in_ch.valid && in_ch.ready;
    out_take = rst_n && out_ch.valid && out_ch.ready;

    if (in_take) begin
      want = profile_event(in_ch.kind, in_ch.thread_id, in_ch.timestamp);
      if (word_typed) want = word_typed_res;
      pending_results = {pending_results, want};
    end

    if (out_take) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {32'd0, out_ch.thread_calls}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.thread_calls !== want.thread_calls)
          report_mismatch("thread_calls", 64'(out_ch.thread_calls),
                          64'(want.thread_calls));
        if (out_ch.thread_cost !== want.thread_cost)
          report_mismatch("thread_cost", 64'(out_ch.thread_cost),
                          64'(want.thread_cost));
        if (out_ch.thread_nesting !== want.thread_nesting)
          report_mismatch("thread_nesting", {48'd0, out_ch.thread_nesting},
                          {48'd0, want.thread_nesting});
        if (out_ch.total_calls !== want.total_calls)
          report_mismatch("total_calls", 64'(out_ch.total_calls),
                          64'(want.total_calls));
        if (out_ch.total_cost !== want.total_cost)
          report_mismatch("total_cost", 64'(out_ch.total_cost),
                          64'(want.total_cost));
        if (out_ch.mismatch !== want.mismatch)
          report_mismatch("mismatch flag", 64'(out_ch.mismatch), 64'(want.mismatch));
      end
    end

    // Watchdog: count cycles in which no word moves on either channel.
    if (in_take || out_take) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one word; return at the edge that accepts it, valid still high.
  task automatic offer_word(logic kind, logic [TID_W-1:0] tid, logic [TS_W-1:0] ts,
                            logic typed, profile_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.thread_id <= tid;
    in_ch.timestamp <= ts;
    word_typed      <= typed;
    word_typed_res  <= res;
    depth_plan[tid] += (kind == KIND_BEGIN) ? 1 : -1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random words: mostly properly nested begin/end pairs on a running clock,
  // the rest begins or ends of random kind with arbitrary timestamps.
  task automatic random_words(int count);
    logic [63:0]      raw;
    logic [TID_W-1:0] tid;
    logic             kind;
    for (int n = 0; n < count; n++) begin
      tid = TID_W'($urandom_range(THREADS - 1));
      if ($urandom_range(99) < 80) begin
        if (depth_plan[tid] <= 0)
          kind = KIND_BEGIN;
        else if (depth_plan[tid] >= 4)
          kind = KIND_END;
        else
          kind = $urandom_range(1) ? KIND_END : KIND_BEGIN;
        // advance the clock; now and then park it just short of the wrap
        if ($urandom_range(49) == 0)
          clock_now = TS_TOP - TS_W'($urandom_range(20000));
        else
          clock_now = clock_now + TS_W'($urandom_range(5000, 1));
        offer_word(kind, tid, clock_now, 1'b0, NO_RESULT);
      end else begin
        raw  = {$urandom(), $urandom()};
        kind = 1'($urandom_range(1));
        offer_word(kind, tid, raw[TS_W-1:0], 1'b0, NO_RESULT);
      end
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_BEGIN;
    in_ch.thread_id = '0;
    in_ch.timestamp = '0;
    word_typed      = 1'b0;
    word_typed_res  = NO_RESULT;
    open_total      = '0;
    calls_sum       = '0;
    cost_sum        = '0;
    for (int i = 0; i < THREADS; i++) begin
      calls_by_thread[i] = '0;
      nest_by_thread[i]  = '0;
      start_time[i]      = '0;
      start_seen[i]      = 1'b0;
      cost_by_thread[i]  = '0;
      depth_plan[i]      = 0;
    end
    clock_now = TS_W'({$urandom(), $urandom()});

    // Hold reset, then release it once and for all.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script, no idling.
    for (int r = 0; r < SCRIPT_LEN; r++)
      offer_word(SCRIPT[r].kind, SCRIPT[r].tid, SCRIPT[r].ts, SCRIPT[r].typed,
                 SCRIPT[r].res);
    drain_results();

    // No idling, with a long receiver hold-off so the block fills and stalls.
    hold_token <= hold_token + 1;
    random_words(100);
    drain_results();

    // Sender idle most of the time.
    idle_pct = 63;
    random_words(100);
    drain_results();

    // Receiver stalling most of the time.
    idle_pct  = 0;
    stall_pct = 63;
    random_words(100);
    drain_results();

    // Both sides idling now and then.
    idle_pct  = 16;
    stall_pct = 16;
    random_words(100);
    drain_results();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
